/* rtl/core/tarw_pkg.sv */
// Shared types and constants of the tar archive header walker.
package tarw_pkg;

    // Header layout
    localparam logic [8:0] BLOCK_LAST = 9'd511;
    localparam logic [8:0] NAME_LEN   = 9'd100;
    localparam logic [8:0] SIZE_AT    = 9'd124;
    localparam logic [8:0] SIZE_LAST  = 9'd134;
    localparam logic [8:0] TYPE_AT    = 9'd156;
    localparam logic [31:0] ROUND_ADD = 32'd511;

    // Characters of interest
    localparam logic [7:0] CH_DIR   = 8'h35;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        REC_ENTRY = 2'd0,
        REC_EMPTY = 2'd1,
        REC_EOF   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       record_kind;
        logic [8:0]  entry_index;
        logic [39:0] data_offset;
        logic [31:0] file_size;
        logic        is_directory;
        logic [9:0]  entries_total;
        logic        last_of_run;
    } t_rec;

    // Up to two records caused by one archive byte, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_rec       rec_first;
        t_rec       rec_second;
    } t_emit;

endpackage

/* rtl/core/tarw_stream_if.sv */
// Valid/ready stream interface carrying one payload per request.
interface tarw_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/tarw_walker.sv */
// Header walk state and per-byte record generation.
module tarw_walker #(
    parameter int MAX_ENTRIES = 512,
    parameter int OFFSET_BITS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tarw_pkg::t_in_item i_item,
    output tarw_pkg::t_emit   o_emit
);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    tarw_pkg::t_phase       r_phase, n_phase;
    logic [8:0]             r_bib, n_bib;
    logic [31:0]            r_acc, n_acc;
    logic                   r_stop, n_stop;
    logic                   r_ended, n_ended;
    logic [7:0]             r_lastc, n_lastc;
    logic                   r_nfz, n_nfz;
    logic [7:0]             r_type, n_type;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [22:0]            r_blocks, n_blocks;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    logic [OFFSET_BITS-1:0] next_pos;
    logic [63:0]            pos_wide;
    logic [31:0]            round_sum;
    logic [22:0]            blocks_dec;
    logic                   dir_flag;
    logic [CNT_W-1:0]       cnt_after;
    logic [31:0]            idx_wide;
    logic [31:0]            total_wide;
    logic                   emit_entry;
    logic                   emit_empty;
    logic                   emit_eof;
    logic [7:0]             b;
    tarw_pkg::t_rec         entry_rec;
    tarw_pkg::t_rec         end_rec;

    // Per-byte derived values
    assign b          = i_item.archive_byte;
    assign next_pos   = r_pos + OFFSET_BITS'(1);
    assign pos_wide   = 64'(next_pos);
    assign round_sum  = r_acc + tarw_pkg::ROUND_ADD;
    assign blocks_dec = (r_blocks != 23'd0) ? (r_blocks - 23'd1) : r_blocks;
    assign dir_flag   = (r_type == tarw_pkg::CH_DIR) ||
                        ((r_acc == 32'd0) && (r_lastc == tarw_pkg::CH_SLASH));

    // Advance the walk by one byte
    always_comb begin
        n_phase    = r_phase;
        n_bib      = r_bib;
        n_acc      = r_acc;
        n_stop     = r_stop;
        n_ended    = r_ended;
        n_lastc    = r_lastc;
        n_nfz      = r_nfz;
        n_type     = r_type;
        n_pos      = r_pos;
        n_blocks   = r_blocks;
        n_cnt      = r_cnt;
        emit_entry = 1'b0;
        emit_empty = 1'b0;
        emit_eof   = 1'b0;
        cnt_after  = r_cnt;
        if (i_fire) begin
            case (r_phase)
                tarw_pkg::PH_HEADER: begin
                    // track the name
                    if (r_bib == 9'd0) begin
                        n_acc   = 32'd0;
                        n_stop  = 1'b0;
                        n_type  = 8'd0;
                        n_nfz   = (b == 8'd0);
                        n_ended = (b == 8'd0);
                        n_lastc = b;
                    end else if (r_bib < tarw_pkg::NAME_LEN) begin
                        if (!r_ended) begin
                            if (b == 8'd0) begin
                                n_ended = 1'b1;
                            end else begin
                                n_lastc = b;
                            end
                        end
                    end
                    // accumulate octal size digits; digit value is the low three bits
                    if ((r_bib inside {[tarw_pkg::SIZE_AT : tarw_pkg::SIZE_LAST]}) &&
                        !r_stop) begin
                        if (b inside {[tarw_pkg::CH_ZERO : tarw_pkg::CH_SEVEN]}) begin
                            n_acc = {r_acc[28:0], b[2:0]};
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                    if (r_bib == tarw_pkg::TYPE_AT) begin
                        n_type = b;
                    end
                    // close the header
                    if (r_bib == tarw_pkg::BLOCK_LAST) begin
                        n_bib = 9'd0;
                        if (r_nfz) begin
                            n_phase    = tarw_pkg::PH_DONE;
                            emit_empty = 1'b1;
                        end else begin
                            if (r_cnt < CNT_MAX) begin
                                emit_entry = 1'b1;
                                n_cnt      = r_cnt + CNT_W'(1);
                            end
                            n_blocks = round_sum[31:9];
                            n_phase  = (round_sum[31:9] != 23'd0) ? tarw_pkg::PH_PAYLOAD
                                                                  : tarw_pkg::PH_HEADER;
                        end
                    end else begin
                        n_bib = r_bib + 9'd1;
                    end
                end
                tarw_pkg::PH_PAYLOAD: begin
                    // skip payload blocks
                    if (r_bib == tarw_pkg::BLOCK_LAST) begin
                        n_bib    = 9'd0;
                        n_blocks = blocks_dec;
                        if (blocks_dec == 23'd0) begin
                            n_phase = tarw_pkg::PH_HEADER;
                        end
                    end else begin
                        n_bib = r_bib + 9'd1;
                    end
                end
                tarw_pkg::PH_DONE: begin
                    n_bib = r_bib;
                end
                default: begin
                    n_phase = tarw_pkg::PH_HEADER;
                end
            endcase
            n_pos     = next_pos;
            cnt_after = n_cnt;
            // end of archive: report unless already ended, then restart
            if (i_item.final_byte) begin
                emit_eof = (n_phase != tarw_pkg::PH_DONE);
                n_phase  = tarw_pkg::PH_HEADER;
                n_bib    = 9'd0;
                n_acc    = 32'd0;
                n_stop   = 1'b0;
                n_ended  = 1'b0;
                n_lastc  = 8'd0;
                n_nfz    = 1'b0;
                n_type   = 8'd0;
                n_pos    = '0;
                n_blocks = 23'd0;
                n_cnt    = '0;
            end
        end
    end

    // Build the records
    assign idx_wide   = 32'(r_cnt);
    assign total_wide = 32'(cnt_after);

    always_comb begin
        entry_rec.record_kind   = tarw_pkg::REC_ENTRY;
        entry_rec.entry_index   = idx_wide[8:0];
        entry_rec.data_offset   = pos_wide[39:0];
        entry_rec.file_size     = r_acc;
        entry_rec.is_directory  = dir_flag;
        entry_rec.entries_total = total_wide[9:0];
        entry_rec.last_of_run   = !emit_eof;

        end_rec.record_kind   = emit_empty ? tarw_pkg::REC_EMPTY : tarw_pkg::REC_EOF;
        end_rec.entry_index   = 9'd0;
        end_rec.data_offset   = pos_wide[39:0];
        end_rec.file_size     = 32'd0;
        end_rec.is_directory  = 1'b0;
        end_rec.entries_total = total_wide[9:0];
        end_rec.last_of_run   = 1'b1;

        o_emit.count      = 2'(emit_entry) + 2'(emit_empty) + 2'(emit_eof);
        o_emit.rec_first  = emit_entry ? entry_rec : end_rec;
        o_emit.rec_second = end_rec;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tarw_pkg::PH_HEADER;
            r_bib    <= 9'd0;
            r_acc    <= 32'd0;
            r_stop   <= 1'b0;
            r_ended  <= 1'b0;
            r_lastc  <= 8'd0;
            r_nfz    <= 1'b0;
            r_type   <= 8'd0;
            r_pos    <= '0;
            r_blocks <= 23'd0;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bib    <= n_bib;
            r_acc    <= n_acc;
            r_stop   <= n_stop;
            r_ended  <= n_ended;
            r_lastc  <= n_lastc;
            r_nfz    <= n_nfz;
            r_type   <= n_type;
            r_pos    <= n_pos;
            r_blocks <= n_blocks;
            r_cnt    <= n_cnt;
        end
    end

    // A payload walk always has blocks left to skip
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tarw_pkg::PH_PAYLOAD) |-> (r_blocks != 23'd0))
        else $error("payload phase with no blocks left");

    // The final byte restarts the walk
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.final_byte) |=>
            ((r_pos == '0) && (r_phase == tarw_pkg::PH_HEADER) && (r_cnt == '0)))
        else $error("walk not restarted after final byte");

    // An empty header and an end-of-archive record never share one byte
    a_no_double_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit_empty && emit_eof))
        else $error("two end records for one byte");
endmodule

/* rtl/core/tarw_rec_queue.sv */
// Small result queue taking up to two records per cycle and giving one.
module tarw_rec_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tarw_pkg::t_emit  i_emit,
    output logic             o_room,
    tarw_stream_if.source    o_out
);
    tarw_pkg::t_rec r_mem [tarw_pkg::QUEUE_DEPTH];

    logic [tarw_pkg::QPTR_W-1:0] r_head, n_head;
    logic [tarw_pkg::QPTR_W-1:0] r_tail, n_tail;
    logic [tarw_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        pop;
    logic [tarw_pkg::QPTR_W-1:0] tail_next;

    assign pop       = o_out.valid && o_out.ready;
    assign tail_next = r_tail + tarw_pkg::QPTR_W'(1);

    // Leave room for a two-record request
    assign o_room        = (r_count <= tarw_pkg::QCNT_W'(tarw_pkg::QUEUE_DEPTH - 2));
    assign o_out.valid   = (r_count != '0);
    assign o_out.payload = r_mem[r_head];

    // Advance pointers and occupancy
    always_comb begin
        n_head  = pop ? (r_head + tarw_pkg::QPTR_W'(1)) : r_head;
        n_tail  = r_tail + tarw_pkg::QPTR_W'(i_emit.count);
        n_count = r_count + tarw_pkg::QCNT_W'(i_emit.count) - tarw_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Store incoming records in order
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_tail] <= i_emit.rec_first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[tail_next] <= i_emit.rec_second;
        end
    end

    // Never overfill
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.count != 2'd0) |->
            (({1'b0, r_count} + 4'(i_emit.count)) <= 4'(tarw_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

    // Occupancy stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tarw_pkg::QCNT_W'(tarw_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

    // A pair of records closes its run only on the second one
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.count == 2'd2) |->
            (i_emit.rec_second.last_of_run && !i_emit.rec_first.last_of_run))
        else $error("record pair out of order");
endmodule

/* rtl/core/tar_archive_header_walker.sv */
// Top level of the tar archive header walker.
//
//  Port    Dir  Payload        Meaning
//  i_in    in   t_in_item      archive byte and final-byte marker
//  o_out   out  t_rec          entry, empty-header and end-of-archive records
//
// One archive byte is taken per cycle unless the input stalls; a byte enters an input
// register, then the walk logic updates the header state and produces its records.
// A byte yields zero, one or two records, which go through a four-deep queue;
// the input stalls only while that queue has fewer than two free slots.
// Reset is synchronous, active low, and returns the walk to the start of an archive.
// The final byte also restarts the walk, so the next byte begins a new archive.
module tar_archive_header_walker #(
    parameter int MAX_ENTRIES = 512,
    parameter int OFFSET_BITS = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tarw_stream_if.sink   i_in,
    tarw_stream_if.source o_out
);
    logic               r_in_valid, n_in_valid;
    tarw_pkg::t_in_item r_in_item;
    logic               room;
    logic               fire;
    tarw_pkg::t_emit    emit;

    // Process the held byte when the queue can take its records
    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || room;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in.valid && i_in.ready) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.payload;
        end
    end

    tarw_walker #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_walker (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_item (r_in_item),
        .o_emit (emit)
    );

    tarw_rec_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_emit (emit),
        .o_room (room),
        .o_out  (o_out)
    );

    // Records appear only for a processed byte
    a_emit_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit.count != 2'd0) |-> fire)
        else $error("record produced without a byte");

    // A held byte blocks new input until processed
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |-> !i_in.ready)
        else $error("input taken while a byte is held");

    // A stalled byte stays in the input register
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held byte lost during stall");
endmodule

/* dv/tar_archive_header_walker_test.sv */
// Self-checking testbench for the tar archive header walker: directed headers, random archives.
module tar_archive_header_walker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REC    = 512;
    localparam int OFF_BITS   = 40;
    localparam int RAND_RECS  = 48;
    localparam int CYCLE_CAP  = 20_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tarw_stream_if #(.t_payload(tarw_pkg::t_in_item)) in_if ();
    tarw_stream_if #(.t_payload(tarw_pkg::t_rec))     rec_if ();

    tar_archive_header_walker #(
        .MAX_ENTRIES (MAX_REC),
        .OFFSET_BITS (OFF_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (rec_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walker state mirrored by the predictor
    logic [8:0]       blk_pos;
    tarw_pkg::t_phase wph;
    logic [31:0]      size_acc;
    logic             size_stop;
    logic             name_done;
    logic [7:0]       name_last;
    logic             name_empty;
    logic [7:0]       type_byte;
    logic [39:0]      arch_pos;
    logic [22:0]      blocks_left;
    logic [9:0]       entry_count;

    tarw_pkg::t_rec pending_records[$];
    int   records_made;
    int   mismatches;
    int   cycles;
    bit   src_idle;
    bit   snk_idle;
    int   stall_left;

    // Hand-typed fields for a directed row, laid over its first predicted record
    bit              typed_armed;
    tarw_pkg::t_kind typed_kind;
    logic [31:0]     typed_len;
    logic            typed_dir;

    typedef struct {
        int              name_len;   // 0: first name byte zero (empty header)
        logic [7:0]      last_ch;
        string           size_txt;   // written from the size field onward
        logic [7:0]      type_ch;
        int              fin_at;     // header byte carrying the final marker, -1 none
        int              pay_cut;    // payload byte carrying the final marker, -1 none
        int              tail;       // junk bytes after the row, last one final
        bit              typed;
        tarw_pkg::t_kind kind;
        logic [31:0]     file_len;
        bit              dir;
    } t_hdr_row;

    t_hdr_row plan [19] = '{
        // one-byte archive
        '{1, "a", "", "0", 0, -1, 0, 1, tarw_pkg::REC_EOF, 32'd0, 1'b0},
        // name runs over 100 bytes, slash at byte 99, zero size
        '{100, "/", "00000000000", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd0, 1'b1},
        '{5, "x", "00000001750", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd1000, 1'b0},
        // slash name but nonzero size
        '{1, "/", "00000000001", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd1, 1'b0},
        '{7, "d", "00000001000", "5", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd512, 1'b1},
        // all-sevens size wraps, rounding skips nothing
        '{9, "b", "77777777777", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'hFFFF_FFFF, 1'b0},
        // octal digits stop at a space
        '{40, "q", "17 ", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd15, 1'b0},
        // no octal digit at all
        '{99, "/", "8", "2", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd0, 1'b1},
        // twelfth size byte is octal but ignored
        '{12, "/", "000000007777", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd511, 1'b0},
        // empty header, then ignored bytes up to the final one
        '{0, "a", "00000000000", "0", -1, -1, 4, 1, tarw_pkg::REC_EMPTY, 32'd0, 1'b0},
        // entry and end of archive from one byte
        '{3, "c", "00000000000", "0", 511, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd0, 1'b0},
        // empty header on the final byte
        '{0, "a", "00000000000", "5", 511, -1, 0, 1, tarw_pkg::REC_EMPTY, 32'd0, 1'b0},
        // archive ends inside a payload
        '{20, "/", "00000003000", "0", -1, 700, 0, 1, tarw_pkg::REC_ENTRY, 32'd1536, 1'b0},
        // final marker on the last payload byte
        '{2, "e", "00000000001", "0", -1, 511, 0, 0, tarw_pkg::REC_ENTRY, 32'd0, 1'b0},
        // partial header
        '{50, "f", "00000000000", "0", 200, -1, 0, 0, tarw_pkg::REC_ENTRY, 32'd0, 1'b0},
        '{6, 8'hFF, "37777777777", 8'hFF, -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'hFFFF_FFFF,
          1'b0},
        // size of exactly 2^32 wraps to zero
        '{8, "/", "40000000000", "0", -1, -1, 0, 1, tarw_pkg::REC_ENTRY, 32'd0, 1'b1},
        // huge payload, cut short
        '{4, "g", "77777777000", "0", -1, 10, 0, 1, tarw_pkg::REC_ENTRY, 32'hFFFF_FE00, 1'b0},
        '{2, "h", "00000000000", "0", 100, -1, 0, 0, tarw_pkg::REC_ENTRY, 32'd0, 1'b0}
    };

    function automatic void restart_walk();
        blk_pos     = '0;
        wph         = tarw_pkg::PH_HEADER;
        size_acc    = '0;
        size_stop   = 1'b0;
        name_done   = 1'b0;
        name_last   = '0;
        name_empty  = 1'b0;
        type_byte   = '0;
        arch_pos    = '0;
        blocks_left = '0;
        entry_count = '0;
    endfunction

    function automatic tarw_pkg::t_rec make_record(tarw_pkg::t_kind k, logic [8:0] idx,
                                                   logic [39:0] off, logic [31:0] len,
                                                   logic dir);
        tarw_pkg::t_rec r;
        r.record_kind   = k;
        r.entry_index   = idx;
        r.data_offset   = off;
        r.file_size     = len;
        r.is_directory  = dir;
        r.entries_total = entry_count;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Advance the walk by one accepted byte and queue the records it causes
    function automatic void walk_archive_byte(logic [7:0] b, logic fin);
        tarw_pkg::t_rec recs[$];
        logic [39:0]    nxt;
        logic [8:0]     at;
        logic [8:0]     idx;
        logic           dir;
        nxt = arch_pos + 40'd1;
        at  = blk_pos;
        if (wph == tarw_pkg::PH_HEADER) begin
            if (at == 9'd0) begin
                size_acc   = '0;
                size_stop  = 1'b0;
                type_byte  = '0;
                name_empty = (b == 8'h00);
                name_done  = (b == 8'h00);
                name_last  = b;
            end else if (at < tarw_pkg::NAME_LEN && !name_done) begin
                if (b == 8'h00)
                    name_done = 1'b1;
                else
                    name_last = b;
            end
            if (at >= tarw_pkg::SIZE_AT && at <= tarw_pkg::SIZE_LAST && !size_stop) begin
                if (b >= tarw_pkg::CH_ZERO && b <= tarw_pkg::CH_SEVEN)
                    size_acc = {size_acc[28:0], 3'b000} + 32'(b - tarw_pkg::CH_ZERO);
                else
                    size_stop = 1'b1;
            end
            if (at == tarw_pkg::TYPE_AT)
                type_byte = b;
            if (at == tarw_pkg::BLOCK_LAST) begin
                blk_pos = '0;
                if (name_empty) begin
                    wph = tarw_pkg::PH_DONE;
                    recs.push_back(make_record(tarw_pkg::REC_EMPTY, '0, nxt, '0, 1'b0));
                end else begin
                    dir = (type_byte == tarw_pkg::CH_DIR) ||
                          (size_acc == '0 && name_last == tarw_pkg::CH_SLASH);
                    if (int'(entry_count) < MAX_REC) begin
                        idx = entry_count[8:0];
                        entry_count++;
                        recs.push_back(make_record(tarw_pkg::REC_ENTRY, idx, nxt, size_acc,
                                                   dir));
                    end
                    blocks_left = 23'((size_acc + tarw_pkg::ROUND_ADD) >> 9);
                    wph = (blocks_left != '0) ? tarw_pkg::PH_PAYLOAD : tarw_pkg::PH_HEADER;
                end
            end else begin
                blk_pos = at + 9'd1;
            end
        end else if (wph == tarw_pkg::PH_PAYLOAD) begin
            if (at == tarw_pkg::BLOCK_LAST) begin
                blk_pos = '0;
                if (blocks_left != '0)
                    blocks_left--;
                if (blocks_left == '0)
                    wph = tarw_pkg::PH_HEADER;
            end else begin
                blk_pos = at + 9'd1;
            end
        end
        arch_pos = nxt;
        if (fin) begin
            if (wph != tarw_pkg::PH_DONE)
                recs.push_back(make_record(tarw_pkg::REC_EOF, '0, nxt, '0, 1'b0));
            restart_walk();
        end
        if (recs.size() > 0) begin
            recs[recs.size() - 1].last_of_run = 1'b1;
            if (typed_armed) begin
                recs[0].record_kind  = typed_kind;
                recs[0].file_size    = typed_len;
                recs[0].is_directory = typed_dir;
                typed_armed = 1'b0;
            end
        end
        records_made += recs.size();
        foreach (recs[i])
            pending_records.push_back(recs[i]);
    endfunction

    // Offer one byte, hold it until taken, then predict
    task automatic put_byte(input logic [7:0] b, input logic fin);
        if (src_idle && $urandom_range(0, 19) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= '{archive_byte: b, final_byte: fin};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        walk_archive_byte(b, fin);
    endtask

    // Send one 512-byte header, stopping early at the final byte
    task automatic send_header(input int name_len, input logic [7:0] last_ch,
                               input string size_txt, input logic [7:0] type_ch,
                               input int fin_at);
        int         i;
        logic [7:0] b;
        for (i = 0; i <= int'(tarw_pkg::BLOCK_LAST); i++) begin
            b = 8'($urandom);
            if (i < int'(tarw_pkg::NAME_LEN)) begin
                if (name_len == 0) begin
                    if (i == 0)
                        b = 8'h00;
                end else if (i < name_len - 1) begin
                    b = 8'($urandom_range(1, 255));
                end else if (i == name_len - 1) begin
                    b = last_ch;
                end else if (i == name_len) begin
                    b = 8'h00;
                end
            end else if (i >= int'(tarw_pkg::SIZE_AT) &&
                         i - int'(tarw_pkg::SIZE_AT) < size_txt.len()) begin
                b = size_txt[i - int'(tarw_pkg::SIZE_AT)];
            end else if (i == int'(tarw_pkg::TYPE_AT)) begin
                b = type_ch;
            end
            put_byte(b, i == fin_at);
            if (i == fin_at)
                return;
        end
    endtask

    function automatic longint payload_bytes();
        return (wph == tarw_pkg::PH_PAYLOAD) ? longint'(blocks_left) * 512 : 0;
    endfunction

    // Send the last header's payload, ending the archive at cut >= 0 or, past 8192 bytes, at random
    task automatic send_payload(input longint cut, output bit ended);
        longint total;
        longint k;
        total = payload_bytes();
        ended = 1'b0;
        if (cut < 0 && total > 8192)
            cut = $urandom_range(0, 1023);
        for (k = 0; k < total; k++) begin
            put_byte(8'($urandom), k == cut);
            if (k == cut) begin
                ended = 1'b1;
                return;
            end
        end
    endtask

    // Random bytes with the final marker on the last one
    task automatic send_tail(input int n);
        int i;
        for (i = 0; i < n; i++)
            put_byte(8'($urandom), i == n - 1);
    endtask

    task automatic rand_header(input int fin_at, output bit empty);
        int         i;
        int         nl;
        logic [7:0] lc;
        logic [7:0] tc;
        string      st;
        nl = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 100);
        lc = ($urandom_range(0, 2) == 0) ? tarw_pkg::CH_SLASH : 8'($urandom_range(1, 255));
        case ($urandom_range(0, 3))
            0: tc = tarw_pkg::CH_DIR;
            1, 2: tc = tarw_pkg::CH_ZERO;
            default: tc = 8'($urandom);
        endcase
        st = "";
        case ($urandom_range(0, 9))
            6: st = $sformatf("%0o ", $urandom_range(0, 2600));
            7: st = $sformatf("%011o", 32'hFFFF_FE00 + $urandom_range(0, 511));
            8: for (i = 0; i < 11; i++)
                   st = $sformatf("%s%0d", st, $urandom_range(0, 7));
            9: for (i = 0; i < 12; i++)
                   st = $sformatf("%s%c", st, 8'($urandom_range(1, 255)));
            default: st = $sformatf("%011o", $urandom_range(0, 2600));
        endcase
        empty = (nl == 0);
        send_header(nl, lc, st, tc, fin_at);
    endtask

    // A well-formed archive of a few headers, ended in one of several ways
    task automatic rand_archive();
        int     nh;
        int     h;
        bit     empty;
        bit     ended;
        longint total;
        longint cut;
        nh = $urandom_range(0, 4);
        for (h = 0; h < nh; h++) begin
            rand_header(-1, empty);
            if (empty) begin
                send_tail($urandom_range(1, 20));
                return;
            end
            total = payload_bytes();
            if (total > 3072)
                cut = $urandom_range(0, 1023);
            else if (total > 0 && $urandom_range(0, 7) == 0)
                cut = $urandom_range(0, int'(total) - 1);
            else
                cut = -1;
            send_payload(cut, ended);
            if (ended)
                return;
        end
        rand_header(($urandom_range(0, 2) == 0) ? int'(tarw_pkg::BLOCK_LAST)
                                                : $urandom_range(0, 511),
                    empty);
    endtask

    function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", nm, want, got);
        end
    endfunction

    // Compare each delivered record with the oldest prediction; stall the receiver
    always @(posedge i_clk) begin : rec_monitor
        tarw_pkg::t_rec want;
        tarw_pkg::t_rec got;
        if (i_rst_n && rec_if.valid && rec_if.ready) begin
            got = rec_if.payload;
            if (pending_records.size() == 0) begin
                mismatches++;
                $error("record with none expected: kind %0d offset %0d",
                       got.record_kind, got.data_offset);
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind",   64'(want.record_kind),   64'(got.record_kind));
                check_field("entry_index",   64'(want.entry_index),   64'(got.entry_index));
                check_field("data_offset",   64'(want.data_offset),   64'(got.data_offset));
                check_field("file_size",     64'(want.file_size),     64'(got.file_size));
                check_field("is_directory",  64'(want.is_directory),  64'(got.is_directory));
                check_field("entries_total", 64'(want.entries_total), 64'(got.entries_total));
                check_field("last_of_run",   64'(want.last_of_run),   64'(got.last_of_run));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            rec_if.ready <= 1'b0;
        end else if (snk_idle && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 9);
            rec_if.ready <= 1'b0;
        end else begin
            rec_if.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        bit ended;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        rec_if.ready  = 1'b0;
        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        stall_left    = 0;
        typed_armed   = 1'b0;
        records_made  = 0;
        mismatches    = 0;
        cycles        = 0;
        restart_walk();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers
        foreach (plan[r]) begin
            typed_armed = plan[r].typed;
            typed_kind  = plan[r].kind;
            typed_len   = plan[r].file_len;
            typed_dir   = plan[r].dir;
            send_header(plan[r].name_len, plan[r].last_ch, plan[r].size_txt,
                        plan[r].type_ch, plan[r].fin_at);
            ended = (plan[r].fin_at >= 0);
            if (!ended)
                send_payload(plan[r].pay_cut, ended);
            if (!ended && plan[r].tail > 0)
                send_tail(plan[r].tail);
            typed_armed = 1'b0;
        end

        // Hold the sender until every record has drained
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() > 0) @(posedge i_clk);

        // Random archives, with some raw noise
        records_made = 0;
        while (records_made < RAND_RECS) begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                send_tail($urandom_range(1, 700));
            else
                rand_archive();
        end

        // Fill the entry list past its limit, at full rate
        src_idle = 1'b0;
        snk_idle = 1'b0;
        for (i = 0; i <= MAX_REC; i++)
            send_header($urandom_range(1, 100), 8'($urandom_range(1, 255)),
                        "00000000000", 8'($urandom), -1);
        send_header(3, tarw_pkg::CH_SLASH, "00000001000", tarw_pkg::CH_ZERO, -1);
        send_payload(-1, ended);
        send_header(5, tarw_pkg::CH_SLASH, "00000000000", tarw_pkg::CH_DIR,
                    int'(tarw_pkg::BLOCK_LAST));

        in_if.valid <= 1'b0;
        while (pending_records.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
